/* hdl/kst_pkg.sv */
// Shared types and constants for the key sorter.
package kst_pkg;

    // Width of the key ports.
    localparam int unsigned PORT_BITS = 32;

    // Per-cycle command broadcast along the row of sort cells.
    typedef struct packed {
        logic insert;   // a new key is placed into the sorted row
        logic shift;    // the row moves one place toward cell 0
    } kst_ctl_t;

endpackage

/* hdl/kst_cell.sv */
// One sort cell: holds a key and takes part in sorted insertion and output shifting.
module kst_cell #(
    parameter int unsigned STORE_BITS = 32,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned IDX        = 0,
    parameter bit          SIGNED_CMP = 1'b1
) (
    input  logic                  aclk,
    input  kst_pkg::kst_ctl_t     ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [STORE_BITS-1:0] new_key,
    input  logic                  prev_lt,
    input  logic [STORE_BITS-1:0] prev_key,
    input  logic [STORE_BITS-1:0] next_key,
    output logic                  lt_out,
    output logic [STORE_BITS-1:0] key_out
);
    import kst_pkg::*;

    // Flipping the sign bit turns signed order into unsigned order
    localparam logic [STORE_BITS-1:0] FLIP =
        SIGNED_CMP ? {1'b1, {(STORE_BITS-1){1'b0}}} : '0;

    logic [STORE_BITS-1:0] key_reg;
    logic [STORE_BITS-1:0] key_next;
    logic                  occupied;

    assign occupied = (count > CNT_W'(IDX));

    // An empty cell acts as plus infinity
    assign lt_out  = !occupied || ((new_key ^ FLIP) < (key_reg ^ FLIP));
    assign key_out = key_reg;

    // Keep, take the new key, take the left neighbor's key, or take the right one's
    always_comb begin
        key_next = key_reg;
        priority if (ctl.shift) begin
            key_next = next_key;
        end else if (ctl.insert && lt_out) begin
            key_next = prev_lt ? prev_key : new_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

/* hdl/key_sorter.sv */
// Top level of the key sorter: control, occupancy count and the row of sort cells.
//
// The sorter collects a set of signed keys, one per s_ transfer, with s_last on the
// final key of the set. Each key is inserted into its sorted place in a row of
// CAPACITY cells in the cycle it is taken, so there is no separate sort phase.
// After the last key, s_ready stays low while the set drains from cell 0, one
// ascending key per m_ transfer, with m_final_res on the largest key. Keys that
// arrive with the row full are dropped, and m_overflow is then high on every
// result of that set. Keys compare as two's complement values of KEY_BITS bits
// (unsigned on the 32 port bits when KEY_BITS is wider), and results carry the
// low KEY_BITS bits, zero above.
module key_sorter #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [kst_pkg::PORT_BITS-1:0]   s_key,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [kst_pkg::PORT_BITS-1:0]   m_sorted_key,
    output logic                                   m_final_res,
    output logic                                   m_overflow
);
    import kst_pkg::*;

    localparam int unsigned STORE_BITS = (KEY_BITS < PORT_BITS) ? KEY_BITS : PORT_BITS;
    localparam bit          SIGNED_CMP = (KEY_BITS <= PORT_BITS);
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             emitting_reg;
    logic             emitting_next;

    logic             s_xfer;
    logic             m_xfer;
    logic             full;
    kst_ctl_t         ctl;

    logic [STORE_BITS-1:0] new_key;
    logic [STORE_BITS-1:0] cell_key [CAPACITY];
    logic                  cell_lt  [CAPACITY];

    assign s_ready = !emitting_reg;
    assign m_valid = emitting_reg;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign new_key = s_key[STORE_BITS-1:0];

    assign ctl.insert = s_xfer && !full;
    assign ctl.shift  = m_xfer;

    // Count, overflow mark and phase
    always_comb begin
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        emitting_next = emitting_reg;
        if (s_xfer) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
            if (s_last) begin
                emitting_next = 1'b1;
            end
        end
        if (m_xfer) begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                emitting_next = 1'b0;
                dropped_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            emitting_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            emitting_reg <= emitting_next;
        end
    end

    // Row of sort cells; cell 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  prev_lt;
        logic [STORE_BITS-1:0] prev_key;
        logic [STORE_BITS-1:0] next_key;

        if (i == 0) begin : g_first
            assign prev_lt  = 1'b0;
            assign prev_key = new_key;
        end else begin : g_mid
            assign prev_lt  = cell_lt[i-1];
            assign prev_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_key = cell_key[i];
        end else begin : g_body
            assign next_key = cell_key[i+1];
        end

        kst_cell #(
            .STORE_BITS (STORE_BITS),
            .CNT_W      (CNT_W),
            .IDX        (i),
            .SIGNED_CMP (SIGNED_CMP)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .count    (count_reg),
            .new_key  (new_key),
            .prev_lt  (prev_lt),
            .prev_key (prev_key),
            .next_key (next_key),
            .lt_out   (cell_lt[i]),
            .key_out  (cell_key[i])
        );
    end

    // Result fields come straight from cell 0 and the control registers
    assign m_sorted_key = signed'(PORT_BITS'(cell_key[0]));
    assign m_final_res  = (count_reg == CNT_W'(1));
    assign m_overflow   = dropped_reg;

endmodule
